// ===== src/sha1mh_pkg.sv =====
package sha1mh_pkg;

    localparam int WORD_W      = 32;
    localparam int BLOCK_WORDS = 16;
    localparam int BLOCK_W     = WORD_W * BLOCK_WORDS;
    localparam int NUM_ROUNDS  = 80;
    localparam int DIGEST_WORDS = 5;

    localparam logic [6:0] LAST_ROUND   = 7'(NUM_ROUNDS - 1);
    localparam logic [5:0] LAST_POS     = 6'd63;
    localparam logic [5:0] LEN_POS      = 6'd56;
    localparam logic [2:0] LAST_WORD_IX = 3'(DIGEST_WORDS - 1);

    localparam logic [7:0] PAD_MARK = 8'h80;

    localparam logic [31:0] H_INIT [DIGEST_WORDS] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
    };

    localparam logic [31:0] K_0 = 32'h5a827999;
    localparam logic [31:0] K_1 = 32'h6ed9eba1;
    localparam logic [31:0] K_2 = 32'h8f1bbcdc;
    localparam logic [31:0] K_3 = 32'hca62c1d6;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_PAD   = 5'b00010,
        ST_ROUND = 5'b00100,
        ST_ADD   = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    typedef enum logic [2:0] {
        PH_MARK = 3'b001,
        PH_ZERO = 3'b010,
        PH_LEN  = 3'b100
    } pad_phase_t;

    typedef enum logic [1:0] {
        SRC_INPUT = 2'd0,
        SRC_MARK  = 2'd1,
        SRC_ZERO  = 2'd2,
        SRC_LEN   = 2'd3
    } byte_src_t;

    typedef struct packed {
        logic       load;
        byte_src_t  byte_src;
        logic [2:0] len_idx;
        logic       count_byte;
        logic       init_work;
        logic       round;
        logic [6:0] round_idx;
        logic       add;
        logic       clear;
        logic [2:0] out_idx;
    } cmd_t;

endpackage

// ===== src/sha1_message_hasher.sv =====
// channel   dir  tdata                 tuser              tlast
// s_axis    in   [7:0] data_byte       [0] no_byte        end_of_message
// m_axis    out  [31:0] digest_word    [2:0] word_index   last_word
//
// Message bytes are taken while idle; each full 64-byte block then holds the input
// through the 80 rounds of the single round unit and one chaining add.
// The final beat adds 1 to 64 pad bytes per padded block, then five digest beats.
// Reset (aresetn low, synchronous) loads the initial hash and clears the length.
// s_axis_tready is low from the final beat until the last digest beat is taken;
// a stalled m_axis holds the current digest word.
module sha1_message_hasher (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] no_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]  m_axis_tuser,   // [2:0] word_index
    output logic        m_axis_tlast
);

    sha1mh_pkg::cmd_t cmd;

    sha1mh_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_no_byte (s_axis_tuser),
        .in_last    (s_axis_tlast),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .cmd        (cmd)
    );

    sha1mh_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .in_byte     (s_axis_tdata),
        .digest_word (m_axis_tdata)
    );

    assign m_axis_tuser = cmd.out_idx;
    assign m_axis_tlast = (cmd.out_idx == sha1mh_pkg::LAST_WORD_IX);

endmodule

// ===== src/sha1mh_ctrl.sv =====
module sha1mh_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               in_no_byte,
    input  logic               in_last,
    output logic               out_valid,
    input  logic               out_ready,
    output sha1mh_pkg::cmd_t   cmd
);

    sha1mh_pkg::state_t     state_reg, state_next;
    sha1mh_pkg::pad_phase_t phase_reg, phase_next;
    logic [5:0] pos_reg, pos_next;
    logic [6:0] round_reg, round_next;
    logic [2:0] out_idx_reg, out_idx_next;
    logic       pad_reg, pad_next;
    logic       done_reg, done_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sha1mh_pkg::ST_IDLE;
            phase_reg   <= sha1mh_pkg::PH_MARK;
            pos_reg     <= '0;
            round_reg   <= '0;
            out_idx_reg <= '0;
            pad_reg     <= 1'b0;
            done_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            round_reg   <= round_next;
            out_idx_reg <= out_idx_next;
            pad_reg     <= pad_next;
            done_reg    <= done_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        round_next   = round_reg;
        out_idx_next = out_idx_reg;
        pad_next     = pad_reg;
        done_next    = done_reg;
        in_ready     = 1'b0;
        out_valid    = 1'b0;

        cmd            = '0;
        cmd.byte_src   = sha1mh_pkg::SRC_INPUT;
        cmd.len_idx    = pos_reg[2:0];
        cmd.round_idx  = round_reg;
        cmd.out_idx    = out_idx_reg;

        case (state_reg)
            sha1mh_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    pad_next   = in_last;
                    phase_next = sha1mh_pkg::PH_MARK;
                    if (in_last) begin
                        state_next = sha1mh_pkg::ST_PAD;
                    end
                    if (!in_no_byte) begin
                        cmd.load       = 1'b1;
                        cmd.count_byte = 1'b1;
                        pos_next       = pos_reg + 6'd1;
                        if (pos_reg == sha1mh_pkg::LAST_POS) begin
                            cmd.init_work = 1'b1;
                            round_next    = '0;
                            state_next    = sha1mh_pkg::ST_ROUND;
                        end
                    end
                end
            end

            sha1mh_pkg::ST_PAD: begin
                cmd.load = 1'b1;
                pos_next = pos_reg + 6'd1;
                case (phase_reg)
                    sha1mh_pkg::PH_MARK: begin
                        cmd.byte_src = sha1mh_pkg::SRC_MARK;
                        phase_next   = sha1mh_pkg::PH_ZERO;
                    end
                    sha1mh_pkg::PH_ZERO: begin
                        if (pos_reg == sha1mh_pkg::LEN_POS) begin
                            cmd.byte_src = sha1mh_pkg::SRC_LEN;
                            phase_next   = sha1mh_pkg::PH_LEN;
                        end else begin
                            cmd.byte_src = sha1mh_pkg::SRC_ZERO;
                        end
                    end
                    default: begin
                        cmd.byte_src = sha1mh_pkg::SRC_LEN;
                    end
                endcase
                if (pos_reg == sha1mh_pkg::LAST_POS) begin
                    cmd.init_work = 1'b1;
                    round_next    = '0;
                    state_next    = sha1mh_pkg::ST_ROUND;
                    // last length byte closes the message
                    if (cmd.byte_src == sha1mh_pkg::SRC_LEN) begin
                        pad_next  = 1'b0;
                        done_next = 1'b1;
                    end
                end
            end

            sha1mh_pkg::ST_ROUND: begin
                cmd.round  = 1'b1;
                round_next = round_reg + 7'd1;
                if (round_reg == sha1mh_pkg::LAST_ROUND) begin
                    state_next = sha1mh_pkg::ST_ADD;
                end
            end

            sha1mh_pkg::ST_ADD: begin
                cmd.add = 1'b1;
                if (done_reg) begin
                    out_idx_next = '0;
                    state_next   = sha1mh_pkg::ST_OUT;
                end else if (pad_reg) begin
                    state_next = sha1mh_pkg::ST_PAD;
                end else begin
                    state_next = sha1mh_pkg::ST_IDLE;
                end
            end

            sha1mh_pkg::ST_OUT: begin
                out_valid = 1'b1;
                if (out_ready) begin
                    if (out_idx_reg == sha1mh_pkg::LAST_WORD_IX) begin
                        cmd.clear  = 1'b1;
                        done_next  = 1'b0;
                        pos_next   = '0;
                        phase_next = sha1mh_pkg::PH_MARK;
                        state_next = sha1mh_pkg::ST_IDLE;
                    end else begin
                        out_idx_next = out_idx_reg + 3'd1;
                    end
                end
            end

            default: begin
                state_next = sha1mh_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/sha1mh_datapath.sv =====
module sha1mh_datapath (
    input  logic               aclk,
    input  logic               aresetn,
    input  sha1mh_pkg::cmd_t   cmd,
    input  logic [7:0]         in_byte,
    output logic [31:0]        digest_word
);

    localparam int BW = sha1mh_pkg::BLOCK_W;

    // 16-word schedule line; word k sits at [BW-1-32k -: 32], word 0 is next in use
    logic [BW-1:0] line_reg, line_next;
    logic [63:0]   count_reg, count_next;
    logic [31:0]   h_reg    [sha1mh_pkg::DIGEST_WORDS];
    logic [31:0]   h_next   [sha1mh_pkg::DIGEST_WORDS];
    logic [31:0]   work_reg [sha1mh_pkg::DIGEST_WORDS];
    logic [31:0]   work_next[sha1mh_pkg::DIGEST_WORDS];

    logic [63:0] len_shift;
    logic [7:0]  byte_sel;
    logic [31:0] w0, w2, w8, w13, w_mix, w_new;
    logic [31:0] fa, fb, fc, fd, fe, f_val, k_val, t_val;

    always_comb begin
        len_shift = count_reg << {cmd.len_idx, 3'b000};
        case (cmd.byte_src)
            sha1mh_pkg::SRC_INPUT: byte_sel = in_byte;
            sha1mh_pkg::SRC_MARK:  byte_sel = sha1mh_pkg::PAD_MARK;
            sha1mh_pkg::SRC_ZERO:  byte_sel = 8'h00;
            sha1mh_pkg::SRC_LEN:   byte_sel = len_shift[63:56];
            default:               byte_sel = 8'h00;
        endcase
    end

    assign w0    = line_reg[BW-1      -: 32];
    assign w2    = line_reg[BW-1-64   -: 32];
    assign w8    = line_reg[BW-1-256  -: 32];
    assign w13   = line_reg[BW-1-416  -: 32];
    assign w_mix = w13 ^ w8 ^ w2 ^ w0;
    assign w_new = {w_mix[30:0], w_mix[31]};

    assign fa = work_reg[0];
    assign fb = work_reg[1];
    assign fc = work_reg[2];
    assign fd = work_reg[3];
    assign fe = work_reg[4];

    always_comb begin
        if (cmd.round_idx < 7'd20) begin
            f_val = (fb & fc) | (~fb & fd);
            k_val = sha1mh_pkg::K_0;
        end else if (cmd.round_idx < 7'd40) begin
            f_val = fb ^ fc ^ fd;
            k_val = sha1mh_pkg::K_1;
        end else if (cmd.round_idx < 7'd60) begin
            f_val = (fb & fc) | (fb & fd) | (fc & fd);
            k_val = sha1mh_pkg::K_2;
        end else begin
            f_val = fb ^ fc ^ fd;
            k_val = sha1mh_pkg::K_3;
        end
    end

    assign t_val = {fa[26:0], fa[31:27]} + f_val + fe + k_val + w0;

    always_comb begin
        line_next  = line_reg;
        count_next = count_reg;
        h_next     = h_reg;
        work_next  = work_reg;

        if (cmd.load) begin
            line_next = {line_reg[BW-9:0], byte_sel};
        end else if (cmd.round) begin
            line_next = {line_reg[BW-33:0], w_new};
        end

        if (cmd.count_byte) begin
            count_next = count_reg + 64'd8;
        end

        if (cmd.init_work) begin
            work_next = h_reg;
        end else if (cmd.round) begin
            work_next[0] = t_val;
            work_next[1] = fa;
            work_next[2] = {fb[1:0], fb[31:2]};
            work_next[3] = fc;
            work_next[4] = fd;
        end

        if (cmd.add) begin
            for (int i = 0; i < sha1mh_pkg::DIGEST_WORDS; i++) begin
                h_next[i] = h_reg[i] + work_reg[i];
            end
        end

        if (cmd.clear) begin
            h_next     = sha1mh_pkg::H_INIT;
            count_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        line_reg <= line_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            h_reg     <= sha1mh_pkg::H_INIT;
            work_reg  <= '{default: '0};
        end else begin
            count_reg <= count_next;
            h_reg     <= h_next;
            work_reg  <= work_next;
        end
    end

    always_comb begin
        case (cmd.out_idx)
            3'd0:    digest_word = h_reg[0];
            3'd1:    digest_word = h_reg[1];
            3'd2:    digest_word = h_reg[2];
            3'd3:    digest_word = h_reg[3];
            3'd4:    digest_word = h_reg[4];
            default: digest_word = h_reg[0];
        endcase
    end

endmodule
